[rtl/chtm_pkg.sv]
package chtm_pkg;

  localparam int CellSlots   = 256;
  localparam int HitsPerCell = 64;
  localparam int SlotW       = $clog2(CellSlots);
  localparam int HitW        = $clog2(HitsPerCell);
  localparam int CntW        = $clog2(HitsPerCell + 1);
  localparam int AddrW       = SlotW + HitW;

  localparam logic [2:0] ST_MERGED     = 3'd0;
  localparam logic [2:0] ST_NEW        = 3'd1;
  localparam logic [2:0] ST_LIST_FULL  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_IGNORED    = 3'd4;
  localparam logic [2:0] ST_DRAINED    = 3'd5;
  localparam logic [2:0] ST_EMPTY      = 3'd6;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_WINDOW    = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_REQ, S_SCAN, S_HIT_REQ, S_HIT_CHK, S_MUL, S_DIV_START, S_DIV_WAIT,
    S_WRITE, S_DR_SCAN_REQ, S_DR_SCAN, S_DR_HIT_REQ, S_DR_HIT, S_DR_END, S_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [47:0] t_num;
    logic [48:0] z_num;
    logic [24:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [19:0] t_q;
    logic [18:0] z_q;
  } div_rsp_t;

endpackage

[rtl/chtm_divider.sv]
// Restoring divider for both weighted averages at once, one quotient bit a cycle.
module chtm_divider import chtm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NumW = 49;

  logic [NumW-1:0] tn, zn, tq, zq;
  logic [24:0]     tr, zr, den;
  logic            zneg, run, done_q;
  logic [5:0]      cnt;
  logic [25:0]     ttry, ztry;
  logic [NumW-1:0] tz_abs;

  // Numerators already hold num + den/2; z is divided by magnitude, then rounded to floor.
  assign tz_abs = req.z_num[48] ? (~req.z_num + 49'd1) : req.z_num;
  assign ttry = {tr, tn[NumW-1]} - {1'b0, den};
  assign ztry = {zr, zn[NumW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        cnt  <= 6'(NumW);
        tn   <= {1'b0, req.t_num};
        zn   <= tz_abs;
        zneg <= req.z_num[48];
        den  <= req.den;
        tr   <= '0;
        zr   <= '0;
      end else if (run) begin
        tn <= {tn[NumW-2:0], 1'b0};
        zn <= {zn[NumW-2:0], 1'b0};
        tq <= {tq[NumW-2:0], !ttry[25]};
        zq <= {zq[NumW-2:0], !ztry[25]};
        tr <= ttry[25] ? {tr[23:0], tn[NumW-1]} : ttry[24:0];
        zr <= ztry[25] ? {zr[23:0], zn[NumW-1]} : ztry[24:0];
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run    <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient of a negative numerator rounds towards minus infinity.
  logic [NumW-1:0] zq_s;
  always_comb begin
    zq_s = zq;
    if (zneg) zq_s = ~zq + ((zr != 25'd0) ? 49'd0 : 49'd1);
  end
  assign rsp.done = done_q;
  assign rsp.t_q  = tq[19:0];
  assign rsp.z_q  = zq_s[18:0];

endmodule

[rtl/cell_hit_time_merge_accumulator.sv]
// Cell hit accumulator. A start is taken only while busy is low; each item yields one or
// more results, each shown for one cycle with result_valid, the final one with last set,
// and the receiver cannot stall them. Cell table and hit lists sit in single-port
// synchronous memories. A deposit scans the cell table at one slot a cycle, then reads
// the stored hits of that cell in turn until one lies within the merge window, and a
// merge adds a serial division; a write state and an output state end the deposit. A
// drain scans the table the same way and then reads the cell's hits in turn, emitting
// results as it goes.
module cell_hit_time_merge_accumulator import chtm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [7:0]         module_req,
  input  logic [6:0]         layer,
  input  logic [8:0]         sector,
  input  logic [19:0]        hit_time,
  input  logic [23:0]        deposit_energy,
  input  logic signed [18:0] hit_z,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               result_valid,
  output logic [2:0]         status,
  output logic [7:0]         out_module,
  output logic [6:0]         out_layer,
  output logic [8:0]         out_sector,
  output logic [19:0]        out_time,
  output logic [23:0]        out_energy,
  output logic signed [18:0] out_z,
  output logic               last
);

  // Configuration registers.
  logic [23:0] energy_threshold;
  logic [19:0] merge_window;
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold <= 24'd1000;
      merge_window     <= 20'd800;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: energy_threshold <= cfg_data;
        CFG_WINDOW:    merge_window     <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Cell table: used bits in flip-flops, key and count in a memory.
  logic [CellSlots-1:0] cell_used;
  logic [23+CntW:0]     cell_mem [CellSlots];
  logic [23+CntW:0]     cell_rd;
  logic [SlotW-1:0]     cell_addr;
  logic                 cell_we;
  logic [23+CntW:0]     cell_wd;

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_addr] <= cell_wd;
    cell_rd <= cell_mem[cell_addr];
  end

  // Hit memory: time, energy and z of every hit.
  logic [62:0]      hit_mem [CellSlots*HitsPerCell];
  logic [62:0]      hit_rd;
  logic [AddrW-1:0] hit_addr;
  logic             hit_we;
  logic [62:0]      hit_wd;

  always_ff @(posedge clk) begin
    if (hit_we) hit_mem[hit_addr] <= hit_wd;
    hit_rd <= hit_mem[hit_addr];
  end

  // Item and working registers.
  state_t state, state_next;
  logic [23:0]       key;
  logic [19:0]       t;
  logic [23:0]       e;
  logic signed [18:0] z;
  logic [SlotW:0]    scan;
  logic [SlotW-1:0]  slot, free_slot;
  logic              found, have_free, any_emit;
  logic [CntW-1:0]   cnt, idx;
  logic [19:0]       ts;
  logic [23:0]       es;
  logic signed [18:0] zs;
  logic [47:0]       tmul;
  logic signed [48:0] zmul;
  logic [2:0]        r_st;
  logic [19:0]       r_t;
  logic [23:0]       r_e;
  logic signed [18:0] r_z;
  logic [23:0]       r_key;
  logic              r_last;

  div_req_t dreq;
  div_rsp_t drsp;
  chtm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [23:0] rd_key;
  logic [CntW-1:0] rd_cnt;
  assign rd_key = cell_rd[23+CntW:CntW];
  assign rd_cnt = cell_rd[CntW-1:0];

  logic [19:0] h_t;
  logic [23:0] h_e;
  logic signed [18:0] h_z;
  assign h_t = hit_rd[62:43];
  assign h_e = hit_rd[42:19];
  assign h_z = hit_rd[18:0];

  logic [19:0] time_gap;
  assign time_gap = (h_t > t) ? h_t - t : t - h_t;

  logic [24:0] den;
  logic [24:0] esum;
  logic [23:0] e_sat;
  assign esum  = {1'b0, es} + {1'b0, e};
  assign den   = esum;
  assign e_sat = esum[24] ? 24'hFFFFFF : esum[23:0];

  logic [SlotW:0] scan_slot;
  assign scan_slot = scan - (SlotW+1)'(1);

  assign busy = (state != S_IDLE);

  // Next-state logic and memory control.
  always_comb begin
    state_next = state;
    cell_addr  = scan[SlotW-1:0];
    cell_we    = 1'b0;
    cell_wd    = {key, cnt};
    hit_addr   = {slot, idx[HitW-1:0]};
    hit_we     = 1'b0;
    hit_wd     = {t, e, z};
    dreq.start = 1'b0;
    dreq.t_num = tmul + {24'd0, den[24:1]};
    dreq.z_num = zmul + {25'd0, den[24:1]};
    dreq.den   = den;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op) state_next = S_DR_SCAN_REQ;
          else if (deposit_energy == 24'd0) state_next = S_EMIT;
          else state_next = S_SCAN_REQ;
        end
      end
      S_SCAN_REQ: state_next = S_SCAN;
      S_SCAN: begin
        cell_addr = scan[SlotW-1:0];
        if (found) state_next = S_HIT_REQ;
        else if (scan == (SlotW+1)'(CellSlots)) begin
          // Table full only when no slot matched and none was free.
          if (have_free || !cell_used[scan_slot[SlotW-1:0]] || rd_key == key)
            state_next = S_HIT_REQ;
          else state_next = S_EMIT;
        end
      end
      S_HIT_REQ: state_next = (found && idx < cnt) ? S_HIT_CHK : S_WRITE;
      S_HIT_CHK: state_next = (time_gap < merge_window) ? S_MUL : S_HIT_REQ;
      S_MUL: state_next = S_DIV_START;
      S_DIV_START: begin
        dreq.start = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (drsp.done) state_next = S_WRITE;
      S_WRITE: begin
        state_next = S_EMIT;
        cell_addr  = slot;
        cell_wd    = {key, cnt + CntW'(1)};
        // A merge rewrites the matched hit; a new hit is appended and counted while the list has room.
        if (idx < cnt) begin
          hit_we = 1'b1;
          hit_wd = {drsp.t_q, e_sat, drsp.z_q};
        end else if (cnt < CntW'(HitsPerCell)) begin
          hit_we  = 1'b1;
          cell_we = 1'b1;
        end
      end
      S_DR_SCAN_REQ: state_next = S_DR_SCAN;
      S_DR_SCAN: if (scan == (SlotW+1)'(CellSlots)) state_next = S_DR_HIT_REQ;
      S_DR_HIT_REQ: state_next = (found && idx < cnt) ? S_DR_HIT : S_DR_END;
      S_DR_HIT: state_next = S_DR_HIT_REQ;
      S_DR_END: state_next = S_EMIT;
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cell_used <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          key <= {module_req, layer, sector};
          t <= hit_time; e <= deposit_energy; z <= hit_z;
          scan <= '0; found <= 1'b0; have_free <= 1'b0; idx <= '0; any_emit <= 1'b0;
          if (!op && deposit_energy == 24'd0) begin
            r_st <= ST_IGNORED; r_key <= {module_req, layer, sector};
            r_t <= '0; r_e <= '0; r_z <= '0; r_last <= 1'b1;
          end
        end
        S_SCAN_REQ: scan <= scan + (SlotW+1)'(1);
        S_SCAN: begin
          // Result of the read at scan_slot is in cell_rd.
          if (!found) begin
            if (cell_used[scan_slot[SlotW-1:0]]) begin
              if (rd_key == key) begin
                found <= 1'b1; slot <= scan_slot[SlotW-1:0];
                cnt <= (rd_cnt > CntW'(HitsPerCell)) ? CntW'(HitsPerCell) : rd_cnt;
              end
            end else if (!have_free) begin
              have_free <= 1'b1; free_slot <= scan_slot[SlotW-1:0];
            end
            if (scan != (SlotW+1)'(CellSlots)) scan <= scan + (SlotW+1)'(1);
          end
          if (!found && scan == (SlotW+1)'(CellSlots) &&
              !(cell_used[scan_slot[SlotW-1:0]] && rd_key == key)) begin
            if (have_free || !cell_used[scan_slot[SlotW-1:0]]) begin
              found <= 1'b1; cnt <= '0;
              slot <= have_free ? free_slot : scan_slot[SlotW-1:0];
              cell_used[have_free ? free_slot : scan_slot[SlotW-1:0]] <= 1'b1;
            end else begin
              r_st <= ST_TABLE_FULL; r_key <= key;
              r_t <= '0; r_e <= '0; r_z <= '0; r_last <= 1'b1;
            end
          end
        end
        S_HIT_REQ: ;
        S_HIT_CHK: begin
          if (time_gap < merge_window) begin
            ts <= h_t; es <= h_e; zs <= h_z;
          end else idx <= idx + CntW'(1);
        end
        S_MUL: begin
          tmul <= 48'(ts) * 48'(es) + 48'(t) * 48'(e);
          zmul <= 49'(zs) * $signed({25'd0, es}) + 49'(z) * $signed({25'd0, e});
        end
        S_DIV_START: ;
        S_DIV_WAIT: ;
        S_WRITE: begin
          r_key <= key; r_last <= 1'b1;
          if (idx < cnt) begin
            r_st <= ST_MERGED; r_t <= drsp.t_q; r_z <= drsp.z_q;
            r_e <= e_sat;
          end else if (cnt >= CntW'(HitsPerCell)) begin
            r_st <= ST_LIST_FULL; r_t <= t; r_e <= e; r_z <= z;
          end else begin
            r_st <= ST_NEW; r_t <= t; r_e <= e; r_z <= z;
          end
        end
        S_DR_SCAN_REQ: scan <= scan + (SlotW+1)'(1);
        S_DR_SCAN: begin
          if (cell_used[scan_slot[SlotW-1:0]] && (!found || rd_key < key)) begin
            found <= 1'b1; slot <= scan_slot[SlotW-1:0]; key <= rd_key;
            cnt <= (rd_cnt > CntW'(HitsPerCell)) ? CntW'(HitsPerCell) : rd_cnt;
          end
          if (scan != (SlotW+1)'(CellSlots)) scan <= scan + (SlotW+1)'(1);
        end
        S_DR_HIT_REQ: ;
        S_DR_HIT: begin
          idx <= idx + CntW'(1);
          // A qualifying hit is held back until the next one qualifies, so that the
          // final one can leave with last set.
          if (h_e >= energy_threshold) begin
            if (any_emit) begin
              result_valid <= 1'b1;
              status <= r_st; {out_module, out_layer, out_sector} <= r_key;
              out_time <= r_t; out_energy <= r_e; out_z <= r_z; last <= 1'b0;
            end
            any_emit <= 1'b1;
            r_st <= ST_DRAINED; r_key <= key;
            r_t <= h_t; r_e <= h_e; r_z <= h_z; r_last <= 1'b1;
          end
        end
        S_DR_END: begin
          if (found) cell_used[slot] <= 1'b0;
          if (!any_emit) begin
            r_st <= ST_EMPTY; r_key <= found ? key : 24'd0;
            r_t <= '0; r_e <= '0; r_z <= '0; r_last <= 1'b1;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          status <= r_st; {out_module, out_layer, out_sector} <= r_key;
          out_time <= r_t; out_energy <= r_e; out_z <= r_z; last <= r_last;
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/sv/tb_cell_hit_time_merge_accumulator.sv]
`timescale 1ns / 100ps
module tb_cell_hit_time_merge_accumulator;
  import chtm_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  mod_id;
    logic [6:0]  lay_id;
    logic [8:0]  sec_id;
    logic [19:0] t;
    logic [23:0] e;
    logic [18:0] z;
    logic        last;
  } cell_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               op;
  logic [7:0]         module_req;
  logic [6:0]         layer;
  logic [8:0]         sector;
  logic [19:0]        hit_time;
  logic [23:0]        deposit_energy;
  logic signed [18:0] hit_z;
  logic               cfg_we;
  logic               cfg_index;
  logic [23:0]        cfg_data;
  logic               result_valid;
  logic [2:0]         status;
  logic [7:0]         out_module;
  logic [6:0]         out_layer;
  logic [8:0]         out_sector;
  logic [19:0]        out_time;
  logic [23:0]        out_energy;
  logic signed [18:0] out_z;
  logic               last;

  // Own copy of the accumulator state and its registers.
  cell_result_t expected_results[$];
  logic [23:0]  threshold_copy;
  logic [19:0]  window_copy;
  bit           slot_used[CellSlots];
  logic [23:0]  slot_key[CellSlots];
  int           slot_hits[CellSlots];
  logic [19:0]  hit_time_copy[CellSlots*HitsPerCell];
  logic [23:0]  hit_energy_copy[CellSlots*HitsPerCell];
  int           hit_z_copy[CellSlots*HitsPerCell];
  int           errors;
  int           burst_left;
  logic [23:0]  key_pool[6];

  cell_hit_time_merge_accumulator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .module_req(module_req), .layer(layer), .sector(sector), .hit_time(hit_time),
    .deposit_energy(deposit_energy), .hit_z(hit_z), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
    .status(status), .out_module(out_module), .out_layer(out_layer),
    .out_sector(out_sector), .out_time(out_time), .out_energy(out_energy),
    .out_z(out_z), .last(last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Energy-weighted average, rounded to nearest with halves going up.
  function automatic longint weighted_round(longint num, longint den);
    longint a;
    a = num + den / 2;
    if (a >= 0) begin
      return a / den;
    end
    return -((-a + den - 1) / den);
  endfunction

  task automatic queue_result(logic [2:0] st, logic [23:0] key, logic [19:0] t,
                              logic [23:0] e, int z, logic fin);
    cell_result_t r;
    r.status = st;
    r.mod_id = key[23:16];
    r.lay_id = key[15:9];
    r.sec_id = key[8:0];
    r.t      = t;
    r.e      = e;
    r.z      = z[18:0];
    r.last   = fin;
    expected_results.push_back(r);
  endtask

  // A drain frees the occupied cell with the smallest key and reads out its hits.
  task automatic predict_drain();
    int slot;
    int total;
    int n;
    int h;
    slot  = -1;
    total = 0;
    n     = 0;
    for (int s = 0; s < CellSlots; s++) begin
      if (slot_used[s] && (slot < 0 || slot_key[s] < slot_key[slot])) begin
        slot = s;
      end
    end
    if (slot < 0) begin
      queue_result(ST_EMPTY, 24'd0, 20'd0, 24'd0, 0, 1'b1);
      return;
    end
    for (int i = 0; i < slot_hits[slot]; i++) begin
      if (hit_energy_copy[slot*HitsPerCell+i] >= threshold_copy) begin
        total++;
      end
    end
    for (int i = 0; i < slot_hits[slot]; i++) begin
      h = slot * HitsPerCell + i;
      if (hit_energy_copy[h] >= threshold_copy) begin
        n++;
        queue_result(ST_DRAINED, slot_key[slot], hit_time_copy[h], hit_energy_copy[h],
                     hit_z_copy[h], n == total);
      end
    end
    if (total == 0) begin
      queue_result(ST_EMPTY, slot_key[slot], 20'd0, 24'd0, 0, 1'b1);
    end
    slot_used[slot] = 1'b0;
    slot_hits[slot] = 0;
  endtask

  // A deposit merges into the first hit within the window, or is appended if the list has room.
  task automatic predict_deposit(logic [23:0] key, logic [19:0] t, logic [23:0] e,
                                 logic signed [18:0] zin);
    int slot;
    int free_slot;
    int h;
    int z;
    logic [19:0] d;
    longint es;
    longint den;
    longint sum;
    slot      = -1;
    free_slot = -1;
    z         = int'(zin);
    if (e == 0) begin
      queue_result(ST_IGNORED, key, 20'd0, 24'd0, 0, 1'b1);
      return;
    end
    for (int s = 0; s < CellSlots; s++) begin
      if (slot_used[s]) begin
        if (slot_key[s] == key) begin
          slot = s;
          break;
        end
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (slot < 0) begin
      if (free_slot < 0) begin
        queue_result(ST_TABLE_FULL, key, 20'd0, 24'd0, 0, 1'b1);
        return;
      end
      slot            = free_slot;
      slot_used[slot] = 1'b1;
      slot_key[slot]  = key;
      slot_hits[slot] = 0;
    end
    for (int i = 0; i < slot_hits[slot]; i++) begin
      h = slot * HitsPerCell + i;
      d = (hit_time_copy[h] > t) ? hit_time_copy[h] - t : t - hit_time_copy[h];
      if (d < window_copy) begin
        es  = longint'(hit_energy_copy[h]);
        den = es + longint'(e);
        sum = den;
        hit_time_copy[h] = 20'(weighted_round(longint'(hit_time_copy[h]) * es
                                              + longint'(t) * longint'(e), den));
        hit_z_copy[h] = int'(weighted_round(longint'(hit_z_copy[h]) * es
                                            + longint'(z) * longint'(e), den));
        hit_energy_copy[h] = (sum > 64'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
        queue_result(ST_MERGED, key, hit_time_copy[h], hit_energy_copy[h],
                     hit_z_copy[h], 1'b1);
        return;
      end
    end
    if (slot_hits[slot] >= HitsPerCell) begin
      queue_result(ST_LIST_FULL, key, t, e, z, 1'b1);
      return;
    end
    h = slot * HitsPerCell + slot_hits[slot];
    hit_time_copy[h]   = t;
    hit_energy_copy[h] = e;
    hit_z_copy[h]      = z;
    slot_hits[slot]++;
    queue_result(ST_NEW, key, t, e, z, 1'b1);
  endtask

  // One transfer of an item, followed by the sender's burst and gap pattern.
  task automatic send_item(logic o, logic [23:0] key, logic [19:0] t, logic [23:0] e,
                           logic signed [18:0] z);
    int gap;
    gap            = 0;
    op             = o;
    module_req     = key[23:16];
    layer          = key[15:9];
    sector         = key[8:0];
    hit_time       = t;
    deposit_energy = e;
    hit_z          = z;
    start          = 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
    if (o) begin
      predict_drain();
    end else begin
      predict_deposit(key, t, e, z);
    end
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic deposit(logic [23:0] key, logic [19:0] t, logic [23:0] e,
                         logic signed [18:0] z);
    send_item(1'b0, key, t, e, z);
  endtask

  task automatic drain();
    send_item(1'b1, 24'd0, 20'd0, 24'd0, 19'sd0);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == CFG_THRESHOLD) begin
      threshold_copy = value;
    end else begin
      window_copy = value[19:0];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drains on an empty table, and zero-energy deposits that must be ignored.
  task automatic test_empty_and_ignored();
    drain();
    deposit(24'hFFFFFF, 20'hFFFFF, 24'd0, -19'sd262144);
    deposit(24'h000000, 20'd5, 24'd0, 19'sd262143);
    drain();
  endtask

  // Field extremes, saturation of the energy and a below-threshold drain.
  task automatic test_extremes();
    write_reg(CFG_THRESHOLD, 24'd0);
    write_reg(CFG_WINDOW, 24'hFFFFF);
    deposit(24'h000000, 20'd0, 24'hFFFFFF, 19'sd262143);
    deposit(24'h000000, 20'hFFFFF, 24'hFFFFFF, -19'sd262144);
    deposit(24'h000000, 20'hFFFFF, 24'd1, -19'sd1);
    deposit(24'hFFFFFF, 20'h80000, 24'd3, -19'sd7);
    deposit(24'hFFFFFF, 20'h00001, 24'd2, 19'sd4);
    drain();
    drain();
    write_reg(CFG_THRESHOLD, 24'hFFFFFF);
    write_reg(CFG_WINDOW, 24'd0);
    deposit(24'h12A5F3, 20'd100, 24'hFFFFFF, 19'sd100);
    deposit(24'h12A5F3, 20'd100, 24'hFFFFFE, -19'sd100);
    deposit(24'h0005AA, 20'd50, 24'd999, 19'sd0);
    drain();
    drain();
    drain();
  endtask

  // A full hit list with a zero window, where equal times must not merge.
  task automatic test_hit_list_full();
    write_reg(CFG_THRESHOLD, 24'd0);
    write_reg(CFG_WINDOW, 24'd0);
    for (int i = 0; i < HitsPerCell; i++) begin
      deposit(24'h3C1234, (i % 4 == 0) ? 20'd777 : 20'($urandom),
              24'($urandom_range(1, 24'hFFFFFF)), 19'($urandom));
    end
    deposit(24'h3C1234, 20'hABCDE, 24'h123456, -19'sd1234);
    drain();
  endtask

  // Every slot of the cell table taken, then one more cell.
  task automatic test_cell_table_full();
    write_reg(CFG_THRESHOLD, 24'd1000);
    write_reg(CFG_WINDOW, 24'd800);
    for (int i = 0; i < CellSlots; i++) begin
      deposit({8'(i), 7'(i * 5), 9'(i * 3)}, 20'($urandom), 24'($urandom_range(1, 2000)),
              19'($urandom));
    end
    deposit(24'hFFFFFF, 20'd10, 24'd5000, 19'sd10);
    deposit({8'd7, 7'd35, 9'd21}, 20'($urandom), 24'd5000, 19'sd0);
    for (int i = 0; i < 8; i++) begin
      drain();
    end
  endtask

  // Random items over a small set of cells so that hits merge often.
  task automatic test_random_phases();
    logic [23:0] thr;
    logic [19:0] win;
    logic [19:0] base;
    logic [23:0] key;
    logic [23:0] e;
    logic [19:0] t;
    int          pick;
    key_pool[0] = 24'h000000;
    key_pool[1] = 24'hFFFFFF;
    for (int k = 2; k < 6; k++) begin
      key_pool[k] = 24'($urandom);
    end
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin thr = 24'd0;        win = 20'd0;        end
        1: begin thr = 24'hFFFFFF;   win = 20'hFFFFF;    end
        2: begin thr = 24'd1000;     win = 20'd800;      end
        default: begin
          thr = 24'($urandom_range(0, 6000));
          win = 20'($urandom_range(1, 3000));
        end
      endcase
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_WINDOW, 24'(win));
      base = 20'($urandom_range(0, 20'hFF000));
      for (int n = 0; n < 14; n++) begin
        pick = $urandom_range(0, 99);
        key  = ($urandom_range(0, 19) == 0) ? 24'($urandom) : key_pool[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
          0:       e = 24'd0;
          1:       e = 24'hFFFFFF;
          2:       e = 24'($urandom);
          default: e = 24'($urandom_range(1, 5000));
        endcase
        t = ($urandom_range(0, 9) == 0) ? 20'($urandom) : base + 20'($urandom_range(0, 4000));
        if (pick < 15) begin
          drain();
        end else begin
          deposit(key, t, e, 19'($urandom));
        end
      end
    end
  endtask

  // Result checker: each result against the oldest expectation.
  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    cell_result_t w;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result with status %0d", status);
        errors++;
      end else begin
        w = expected_results.pop_front();
        compare_field("status", w.status, status);
        compare_field("out_module", w.mod_id, out_module);
        compare_field("out_layer", w.lay_id, out_layer);
        compare_field("out_sector", w.sec_id, out_sector);
        compare_field("out_time", w.t, out_time);
        compare_field("out_energy", w.e, out_energy);
        compare_field("out_z", w.z, $unsigned(out_z));
        compare_field("last", w.last, last);
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("cell_hit_time_merge_accumulator test failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    op             = 1'b0;
    module_req     = '0;
    layer          = '0;
    sector         = '0;
    hit_time       = '0;
    deposit_energy = '0;
    hit_z          = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_THRESHOLD;
    cfg_data       = '0;
    errors         = 0;
    burst_left     = 0;
    threshold_copy = 24'd1000;
    window_copy    = 20'd800;
    for (int s = 0; s < CellSlots; s++) begin
      slot_used[s] = 1'b0;
      slot_hits[s] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_empty_and_ignored();
    test_extremes();
    test_hit_list_full();
    test_random_phases();
    test_cell_table_full();
    wait_idle();
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("cell_hit_time_merge_accumulator test passed");
    end else begin
      $display("cell_hit_time_merge_accumulator test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/chtm_pkg.sv
rtl/chtm_divider.sv
rtl/cell_hit_time_merge_accumulator.sv
tb/sv/tb_cell_hit_time_merge_accumulator.sv
